// ----- rtl/core/rrp_pkg.sv -----
// Shared types and constants for the request byte parser.
`timescale 1ns / 1ps

package rrp_pkg;

  // Configuration register indexes and widths
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 30;
  localparam int ARGMAX_W   = 16;
  localparam int LENMAX_W   = 30;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_ARG_COUNT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BULK_LENGTH = 1'd1;

  localparam logic [ARGMAX_W-1:0] ARGMAX_RESET = 16'd65535;
  localparam logic [LENMAX_W-1:0] LENMAX_RESET = 30'd536870912;

  // Result kinds
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_DATA   = 2'd0;
  localparam kind_t KIND_ARGEND = 2'd1;
  localparam kind_t KIND_CMDEND = 2'd2;
  localparam kind_t KIND_ERROR  = 2'd3;

  // Parser modes
  localparam int MODE_W = 3;
  localparam logic [MODE_W-1:0] MODE_IDLE   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_COUNT  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ELEM   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LEN    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DATA   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_SKIP   = 3'd5;
  localparam logic [MODE_W-1:0] MODE_INLINE = 3'd6;
  localparam logic [MODE_W-1:0] MODE_DEAD   = 3'd7;

  // Number scanner phases
  localparam logic [1:0] PH_PRE    = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  // Characters
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam int NUM_W = 32;

  // Result queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } result_t;

endpackage

// ----- rtl/core/rrp_num.sv -----
// Decimal number scanner with sign and saturation, one character per cycle while feed is high.
`timescale 1ns / 1ps

module rrp_num (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      clr,
  input  logic                      feed,
  input  logic [7:0]                ch,
  output logic [rrp_pkg::NUM_W-1:0] value,
  output logic                      negative
);

  logic [rrp_pkg::NUM_W-1:0] value_r, value_nxt;
  logic                      neg_r, neg_nxt;
  logic [1:0]                phase_r, phase_nxt;
  logic                      is_digit;
  logic                      is_ws;
  logic [rrp_pkg::NUM_W+3:0] acc;
  logic [rrp_pkg::NUM_W-1:0] acc_sat;

  assign is_digit = (ch >= rrp_pkg::CH_ZERO) && (ch <= rrp_pkg::CH_NINE);
  assign is_ws    = (ch == rrp_pkg::CH_SPACE) || (ch == rrp_pkg::CH_TAB) ||
                    (ch == rrp_pkg::CH_LF) || (ch == rrp_pkg::CH_VT) ||
                    (ch == rrp_pkg::CH_FF) || (ch == rrp_pkg::CH_CR);

  // value * 10 + digit as shift-add, saturate at all ones
  assign acc     = {1'b0, value_r, 3'b000} + {3'b000, value_r, 1'b0}
                 + {(rrp_pkg::NUM_W)'(0), ch[3:0] - rrp_pkg::CH_ZERO[3:0]};
  assign acc_sat = (acc[rrp_pkg::NUM_W+3:rrp_pkg::NUM_W] != 4'd0) ?
                   {rrp_pkg::NUM_W{1'b1}} : acc[rrp_pkg::NUM_W-1:0];

  always_comb begin
    value_nxt = value_r;
    neg_nxt   = neg_r;
    phase_nxt = phase_r;
    if (clr) begin
      value_nxt = '0;
      neg_nxt   = 1'b0;
      phase_nxt = rrp_pkg::PH_PRE;
    end else if (feed) begin
      unique case (phase_r)
        rrp_pkg::PH_PRE: begin
          if (is_ws) begin
            phase_nxt = rrp_pkg::PH_PRE;
          end else if (ch == rrp_pkg::CH_PLUS || ch == rrp_pkg::CH_MINUS) begin
            neg_nxt   = (ch == rrp_pkg::CH_MINUS);
            phase_nxt = rrp_pkg::PH_DIGITS;
          end else if (is_digit) begin
            value_nxt = acc_sat;
            phase_nxt = rrp_pkg::PH_DIGITS;
          end else begin
            phase_nxt = rrp_pkg::PH_DONE;
          end
        end
        rrp_pkg::PH_DIGITS: begin
          if (is_digit) begin
            value_nxt = acc_sat;
          end else begin
            phase_nxt = rrp_pkg::PH_DONE;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= '0;
      neg_r   <= 1'b0;
      phase_r <= rrp_pkg::PH_PRE;
    end else begin
      value_r <= value_nxt;
      neg_r   <= neg_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign value    = value_r;
  assign negative = neg_r;

endmodule

// ----- rtl/core/rrp_outq.sv -----
// Four-entry result queue; takes up to two results per cycle, gives one per cycle while out_ready is high.
`timescale 1ns / 1ps

module rrp_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       push_cnt,
  input  rrp_pkg::result_t push0,
  input  rrp_pkg::result_t push1,
  output logic             room2,
  output logic             out_valid,
  input  logic             out_ready,
  output rrp_pkg::result_t out_res
);

  rrp_pkg::result_t mem [rrp_pkg::QDEPTH];

  logic [rrp_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [rrp_pkg::QCNT_W-1:0] count_r;
  logic                       pop;

  assign out_valid = (count_r != '0);
  assign pop       = out_valid && out_ready;
  assign room2     = (count_r <= rrp_pkg::QCNT_W'(rrp_pkg::QDEPTH - 2));
  assign out_res   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr_r + rrp_pkg::QPTR_W'(1)] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + rrp_pkg::QPTR_W'(push_cnt);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + rrp_pkg::QPTR_W'(1);
      end
      count_r <= count_r + rrp_pkg::QCNT_W'(push_cnt) - rrp_pkg::QCNT_W'(pop);
    end
  end

endmodule

// ----- rtl/core/resp_request_parser.sv -----
// Streaming request parser: array/bulk and inline commands, one byte per request.
// Results: a byte's results enter the result queue when the byte is accepted and leave it in order.
// Throughput: one byte per cycle while bytes give at most one result each and the output
//   drains every cycle; results queue in four entries and in_ready needs two free ones.
// Reset (synchronous, rst_n low): parser to idle, limits to their defaults, queue emptied.
`timescale 1ns / 1ps

module resp_request_parser #(
  parameter int COUNT_BITS  = 16,
  parameter int LENGTH_BITS = 30
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [rrp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rrp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_kind,
  output logic [7:0]                     out_data_byte,
  output logic                           out_last
);

  logic [rrp_pkg::ARGMAX_W-1:0] max_arg_r;
  logic [rrp_pkg::LENMAX_W-1:0] max_len_r;

  logic [rrp_pkg::MODE_W-1:0] mode_r, mode_nxt;
  logic [COUNT_BITS-1:0]      args_left_r, args_left_nxt;
  logic [LENGTH_BITS-1:0]     bytes_left_r, bytes_left_nxt;
  logic                       skip_first_r, skip_first_nxt;
  logic                       pending_cr_r, pending_cr_nxt;
  logic                       token_open_r, token_open_nxt;
  logic                       line_tok_r, line_tok_nxt;

  logic                       accept;
  logic                       crlf;
  logic                       num_clr, num_feed;
  logic [rrp_pkg::NUM_W-1:0]  num_value;
  logic                       num_neg;
  logic                       count_bad, len_bad;
  logic [LENGTH_BITS-1:0]     bytes_dec;
  rrp_pkg::result_t           res [2];
  logic [1:0]                 nres;
  logic                       room2;
  rrp_pkg::result_t           head;

  assign accept = in_valid && in_ready;
  assign in_ready = room2;
  assign crlf   = pending_cr_r && (in_byte == rrp_pkg::CH_LF);

  assign count_bad = (num_value == '0) || num_neg ||
                     (num_value > {{(rrp_pkg::NUM_W-rrp_pkg::ARGMAX_W){1'b0}}, max_arg_r}) ||
                     ((num_value >> COUNT_BITS) != '0);
  assign len_bad   = (num_neg && (num_value != '0)) ||
                     (num_value > {{(rrp_pkg::NUM_W-rrp_pkg::LENMAX_W){1'b0}}, max_len_r}) ||
                     ((num_value >> LENGTH_BITS) != '0);
  assign bytes_dec = bytes_left_r - LENGTH_BITS'(1);

  rrp_num u_num (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (num_clr),
    .feed     (num_feed),
    .ch       (in_byte),
    .value    (num_value),
    .negative (num_neg)
  );

  always_comb begin
    mode_nxt       = mode_r;
    args_left_nxt  = args_left_r;
    bytes_left_nxt = bytes_left_r;
    skip_first_nxt = skip_first_r;
    pending_cr_nxt = pending_cr_r;
    token_open_nxt = token_open_r;
    line_tok_nxt   = line_tok_r;
    num_clr        = 1'b0;
    num_feed       = 1'b0;
    res[0]         = '0;
    res[1]         = '0;
    nres           = 2'd0;

    unique case (mode_r)
      rrp_pkg::MODE_IDLE: begin
        pending_cr_nxt = 1'b0;
        token_open_nxt = 1'b0;
        line_tok_nxt   = 1'b0;
        if (in_byte == rrp_pkg::CH_STAR) begin
          num_clr  = 1'b1;
          mode_nxt = rrp_pkg::MODE_COUNT;
        end else begin
          mode_nxt = rrp_pkg::MODE_INLINE;
          if (in_byte == rrp_pkg::CH_CR) begin
            pending_cr_nxt = 1'b1;
          end else if (in_byte != rrp_pkg::CH_SPACE) begin
            res[0]         = '{rrp_pkg::KIND_DATA, in_byte, 1'b0};
            nres           = 2'd1;
            token_open_nxt = 1'b1;
            line_tok_nxt   = 1'b1;
          end
        end
      end
      rrp_pkg::MODE_COUNT: begin
        if (crlf) begin
          pending_cr_nxt = 1'b0;
          if (count_bad) begin
            res[0]   = '{rrp_pkg::KIND_ERROR, 8'd0, 1'b0};
            nres     = 2'd1;
            mode_nxt = rrp_pkg::MODE_DEAD;
          end else begin
            args_left_nxt = num_value[COUNT_BITS-1:0];
            mode_nxt      = rrp_pkg::MODE_ELEM;
          end
        end else begin
          num_feed       = 1'b1;
          pending_cr_nxt = (in_byte == rrp_pkg::CH_CR);
        end
      end
      rrp_pkg::MODE_ELEM: begin
        if (in_byte == rrp_pkg::CH_DOLLAR) begin
          num_clr        = 1'b1;
          pending_cr_nxt = 1'b0;
          mode_nxt       = rrp_pkg::MODE_LEN;
        end else begin
          res[0]   = '{rrp_pkg::KIND_ERROR, 8'd0, 1'b0};
          nres     = 2'd1;
          mode_nxt = rrp_pkg::MODE_DEAD;
        end
      end
      rrp_pkg::MODE_LEN: begin
        if (crlf) begin
          pending_cr_nxt = 1'b0;
          if (len_bad) begin
            res[0]   = '{rrp_pkg::KIND_ERROR, 8'd0, 1'b0};
            nres     = 2'd1;
            mode_nxt = rrp_pkg::MODE_DEAD;
          end else if (num_value == '0) begin
            // empty bulk string: argument ends right on the length line
            res[0]         = '{rrp_pkg::KIND_ARGEND, 8'd0, 1'b0};
            nres           = 2'd1;
            args_left_nxt  = args_left_r - COUNT_BITS'(1);
            skip_first_nxt = 1'b1;
            mode_nxt       = rrp_pkg::MODE_SKIP;
          end else begin
            bytes_left_nxt = num_value[LENGTH_BITS-1:0];
            mode_nxt       = rrp_pkg::MODE_DATA;
          end
        end else begin
          num_feed       = 1'b1;
          pending_cr_nxt = (in_byte == rrp_pkg::CH_CR);
        end
      end
      rrp_pkg::MODE_DATA: begin
        res[0]         = '{rrp_pkg::KIND_DATA, in_byte, 1'b0};
        nres           = 2'd1;
        bytes_left_nxt = bytes_dec;
        if (bytes_dec == '0) begin
          res[1]         = '{rrp_pkg::KIND_ARGEND, 8'd0, 1'b0};
          nres           = 2'd2;
          args_left_nxt  = args_left_r - COUNT_BITS'(1);
          skip_first_nxt = 1'b1;
          mode_nxt       = rrp_pkg::MODE_SKIP;
        end
      end
      rrp_pkg::MODE_SKIP: begin
        // drop the two trailer bytes unchecked
        skip_first_nxt = 1'b0;
        if (!skip_first_r) begin
          if (args_left_r == '0) begin
            res[0]   = '{rrp_pkg::KIND_CMDEND, 8'd0, 1'b0};
            nres     = 2'd1;
            mode_nxt = rrp_pkg::MODE_IDLE;
          end else begin
            mode_nxt = rrp_pkg::MODE_ELEM;
          end
        end
      end
      rrp_pkg::MODE_INLINE: begin
        if (crlf) begin
          pending_cr_nxt = 1'b0;
          if (!line_tok_r) begin
            res[0] = '{rrp_pkg::KIND_ERROR, 8'd0, 1'b0};
            nres   = 2'd1;
          end else if (token_open_r) begin
            res[0] = '{rrp_pkg::KIND_ARGEND, 8'd0, 1'b0};
            res[1] = '{rrp_pkg::KIND_CMDEND, 8'd0, 1'b0};
            nres   = 2'd2;
          end else begin
            res[0] = '{rrp_pkg::KIND_CMDEND, 8'd0, 1'b0};
            nres   = 2'd1;
          end
          token_open_nxt = 1'b0;
          line_tok_nxt   = 1'b0;
          mode_nxt       = rrp_pkg::MODE_IDLE;
        end else begin
          // a held CR not followed by LF is plain data
          if (pending_cr_r) begin
            res[0]         = '{rrp_pkg::KIND_DATA, rrp_pkg::CH_CR, 1'b0};
            nres           = 2'd1;
            token_open_nxt = 1'b1;
            line_tok_nxt   = 1'b1;
          end
          if (in_byte == rrp_pkg::CH_CR) begin
            pending_cr_nxt = 1'b1;
          end else begin
            pending_cr_nxt = 1'b0;
            if (in_byte == rrp_pkg::CH_SPACE) begin
              if (token_open_nxt) begin
                res[nres[0]] = '{rrp_pkg::KIND_ARGEND, 8'd0, 1'b0};
                nres         = nres + 2'd1;
              end
              token_open_nxt = 1'b0;
            end else begin
              res[nres[0]]   = '{rrp_pkg::KIND_DATA, in_byte, 1'b0};
              nres           = nres + 2'd1;
              token_open_nxt = 1'b1;
              line_tok_nxt   = 1'b1;
            end
          end
        end
      end
      default: begin
        mode_nxt = rrp_pkg::MODE_DEAD;
      end
    endcase

    if (nres != 2'd0) begin
      res[nres[1]].last = 1'b1;
    end
    if (!accept) begin
      num_clr  = 1'b0;
      num_feed = 1'b0;
    end
  end

  rrp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (accept ? nres : 2'd0),
    .push0     (res[0]),
    .push1     (res[1]),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (head)
  );

  assign out_kind      = head.kind;
  assign out_data_byte = head.data;
  assign out_last      = head.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_arg_r <= rrp_pkg::ARGMAX_RESET;
      max_len_r <= rrp_pkg::LENMAX_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        rrp_pkg::REG_MAX_ARG_COUNT:   max_arg_r <= cfg_data[rrp_pkg::ARGMAX_W-1:0];
        rrp_pkg::REG_MAX_BULK_LENGTH: max_len_r <= cfg_data[rrp_pkg::LENMAX_W-1:0];
        default: begin
          max_arg_r <= max_arg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= rrp_pkg::MODE_IDLE;
      args_left_r  <= '0;
      bytes_left_r <= '0;
      skip_first_r <= 1'b0;
      pending_cr_r <= 1'b0;
      token_open_r <= 1'b0;
      line_tok_r   <= 1'b0;
    end else if (accept) begin
      mode_r       <= mode_nxt;
      args_left_r  <= args_left_nxt;
      bytes_left_r <= bytes_left_nxt;
      skip_first_r <= skip_first_nxt;
      pending_cr_r <= pending_cr_nxt;
      token_open_r <= token_open_nxt;
      line_tok_r   <= line_tok_nxt;
    end
  end

endmodule

// ----- rtl/core/rrp_checker.sv -----
// Port-level checks for the request parser, bound to its top level.
`timescale 1ns / 1ps

module rrp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_data_byte,
  input logic       out_last
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
                                $stable(out_data_byte) && $stable(out_last))
    else $error("stalled result changed");

  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != rrp_pkg::KIND_DATA) |-> (out_data_byte == 8'd0))
    else $error("nonzero data byte on a marker result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("queue not empty after reset");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with no result pending");

endmodule

bind resp_request_parser rrp_checker u_rrp_checker (.*);

// ----- sim/tb_top.sv -----
// Self-checking testbench for the request byte parser, with a built-in parse model.
`timescale 1ns / 1ps

module tb_top;

  localparam int COUNT_BITS  = 16;
  localparam int LENGTH_BITS = 30;
  localparam logic [32:0] COUNT_MAX = (33'd1 << COUNT_BITS) - 33'd1;
  localparam logic [32:0] LEN_MAX   = (33'd1 << LENGTH_BITS) - 33'd1;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_BYTES    = 250;

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} row_check_t;

  typedef struct {
    logic [7:0]      b;
    row_check_t      chk;
    rrp_pkg::kind_t  k;
    logic [7:0]      d;
  } dir_row_t;

  typedef enum int {
    BAD_ZERO_COUNT, BAD_NEG_COUNT, BAD_BIG_COUNT, BAD_NO_DOLLAR,
    BAD_NEG_LEN, BAD_BIG_LEN, BAD_OVERFLOW
  } fault_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [rrp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rrp_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_byte = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_data_byte;
  logic out_last;

  // shadow of the directed row that travels with in_byte
  row_check_t row_chk = CHK_MODEL;
  rrp_pkg::kind_t row_kind = rrp_pkg::KIND_DATA;
  logic [7:0] row_data = 8'h00;

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int unsigned rx_wait = 0;
  int unsigned idle_cycles = 0;
  int unsigned mismatch_count = 0;
  int unsigned bytes_sent = 0;

  rrp_pkg::result_t expected_results[$];
  rrp_pkg::result_t step_res[$];
  logic [7:0] cmd_bytes[$];

  // parse model state
  logic [rrp_pkg::MODE_W-1:0] pmode;
  logic [31:0] args_remaining;
  logic [31:0] num_val;
  logic num_neg;
  logic [1:0] num_ph;
  logic [31:0] bytes_remaining;
  logic [1:0] skips_remaining;
  logic cr_held;
  logic token_live;
  logic line_tokens;
  logic [rrp_pkg::ARGMAX_W-1:0] arg_limit;
  logic [rrp_pkg::LENMAX_W-1:0] len_limit;

  dir_row_t directed_rows [23] = '{
    '{rrp_pkg::CH_STAR,   CHK_MODEL, rrp_pkg::KIND_DATA,   8'h00},
    '{"1",                CHK_MODEL, rrp_pkg::KIND_DATA,   8'h00},
    '{rrp_pkg::CH_CR,     CHK_MODEL, rrp_pkg::KIND_DATA,   8'h00},
    '{rrp_pkg::CH_LF,     CHK_MODEL, rrp_pkg::KIND_DATA,   8'h00},
    '{rrp_pkg::CH_DOLLAR, CHK_MODEL, rrp_pkg::KIND_DATA,   8'h00},
    '{"0",                CHK_MODEL, rrp_pkg::KIND_DATA,   8'h00},
    '{rrp_pkg::CH_CR,     CHK_MODEL, rrp_pkg::KIND_DATA,   8'h00},
    '{rrp_pkg::CH_LF,     CHK_ONE,   rrp_pkg::KIND_ARGEND, 8'h00},
    '{8'h00,              CHK_NONE,  rrp_pkg::KIND_DATA,   8'h00},
    '{8'hFF,              CHK_ONE,   rrp_pkg::KIND_CMDEND, 8'h00},
    '{rrp_pkg::CH_CR,     CHK_NONE,  rrp_pkg::KIND_DATA,   8'h00},
    '{rrp_pkg::CH_LF,     CHK_ONE,   rrp_pkg::KIND_ERROR,  8'h00},
    '{rrp_pkg::CH_SPACE,  CHK_NONE,  rrp_pkg::KIND_DATA,   8'h00},
    '{8'hFF,              CHK_ONE,   rrp_pkg::KIND_DATA,   8'hFF},
    '{rrp_pkg::CH_CR,     CHK_NONE,  rrp_pkg::KIND_DATA,   8'h00},
    '{8'h00,              CHK_MODEL, rrp_pkg::KIND_DATA,   8'h00},
    '{rrp_pkg::CH_SPACE,  CHK_ONE,   rrp_pkg::KIND_ARGEND, 8'h00},
    '{rrp_pkg::CH_CR,     CHK_NONE,  rrp_pkg::KIND_DATA,   8'h00},
    '{rrp_pkg::CH_LF,     CHK_ONE,   rrp_pkg::KIND_CMDEND, 8'h00},
    '{"x",                CHK_ONE,   rrp_pkg::KIND_DATA,   "x"},
    '{rrp_pkg::CH_CR,     CHK_NONE,  rrp_pkg::KIND_DATA,   8'h00},
    '{rrp_pkg::CH_CR,     CHK_ONE,   rrp_pkg::KIND_DATA,   rrp_pkg::CH_CR},
    '{rrp_pkg::CH_LF,     CHK_MODEL, rrp_pkg::KIND_DATA,   8'h00}
  };

  resp_request_parser #(
    .COUNT_BITS(COUNT_BITS),
    .LENGTH_BITS(LENGTH_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_byte(in_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_kind(out_kind),
    .out_data_byte(out_data_byte),
    .out_last(out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- parse model

  function automatic void reset_model();
    pmode = rrp_pkg::MODE_IDLE;
    args_remaining = '0;
    num_val = '0;
    num_neg = 1'b0;
    num_ph = rrp_pkg::PH_PRE;
    bytes_remaining = '0;
    skips_remaining = '0;
    cr_held = 1'b0;
    token_live = 1'b0;
    line_tokens = 1'b0;
    arg_limit = rrp_pkg::ARGMAX_RESET;
    len_limit = rrp_pkg::LENMAX_RESET;
  endfunction

  function automatic void add_result(input rrp_pkg::kind_t k, input logic [7:0] d);
    rrp_pkg::result_t r;
    r.kind = k;
    r.data = d;
    r.last = 1'b0;
    step_res.insert(step_res.size(), r);
  endfunction

  function automatic void num_restart();
    num_val = '0;
    num_neg = 1'b0;
    num_ph = rrp_pkg::PH_PRE;
  endfunction

  // atoi-style scan: skip blanks, one sign, digits until the first non digit
  function automatic void scan_char(input logic [7:0] b);
    logic is_digit;
    logic [35:0] acc;
    is_digit = (b >= rrp_pkg::CH_ZERO && b <= rrp_pkg::CH_NINE);
    if (num_ph == rrp_pkg::PH_PRE) begin
      if (b == rrp_pkg::CH_SPACE || b == rrp_pkg::CH_TAB || b == rrp_pkg::CH_LF ||
          b == rrp_pkg::CH_VT || b == rrp_pkg::CH_FF || b == rrp_pkg::CH_CR)
        return;
      if (b == rrp_pkg::CH_PLUS || b == rrp_pkg::CH_MINUS) begin
        num_neg = (b == rrp_pkg::CH_MINUS);
        num_ph = rrp_pkg::PH_DIGITS;
        return;
      end
      if (!is_digit) begin
        num_ph = rrp_pkg::PH_DONE;
        return;
      end
      num_ph = rrp_pkg::PH_DIGITS;
    end
    if (num_ph == rrp_pkg::PH_DIGITS) begin
      if (is_digit) begin
        acc = 36'(num_val) * 36'd10 + 36'(b - rrp_pkg::CH_ZERO);
        num_val = (acc > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
      end else begin
        num_ph = rrp_pkg::PH_DONE;
      end
    end
  endfunction

  function automatic void array_error();
    add_result(rrp_pkg::KIND_ERROR, 8'h00);
    pmode = rrp_pkg::MODE_DEAD;
  endfunction

  function automatic void inline_char(input logic [7:0] c);
    if (c == rrp_pkg::CH_SPACE) begin
      if (token_live) begin
        add_result(rrp_pkg::KIND_ARGEND, 8'h00);
        token_live = 1'b0;
      end
    end else begin
      add_result(rrp_pkg::KIND_DATA, c);
      token_live = 1'b1;
      line_tokens = 1'b1;
    end
  endfunction

  function automatic void close_arg();
    add_result(rrp_pkg::KIND_ARGEND, 8'h00);
    args_remaining = args_remaining - 32'd1;
    skips_remaining = 2'd2;
    pmode = rrp_pkg::MODE_SKIP;
  endfunction

  function automatic void predict_byte(input logic [7:0] b);
    logic crlf;
    crlf = cr_held && b == rrp_pkg::CH_LF;
    step_res.delete();
    case (pmode)
      rrp_pkg::MODE_IDLE: begin
        cr_held = 1'b0;
        token_live = 1'b0;
        line_tokens = 1'b0;
        if (b == rrp_pkg::CH_STAR) begin
          num_restart();
          pmode = rrp_pkg::MODE_COUNT;
        end else begin
          pmode = rrp_pkg::MODE_INLINE;
          if (b == rrp_pkg::CH_CR) cr_held = 1'b1;
          else inline_char(b);
        end
      end
      rrp_pkg::MODE_COUNT: begin
        if (crlf) begin
          cr_held = 1'b0;
          if (num_val == 0 || num_neg || num_val > arg_limit || num_val > COUNT_MAX) begin
            array_error();
          end else begin
            args_remaining = num_val;
            pmode = rrp_pkg::MODE_ELEM;
          end
        end else begin
          scan_char(b);
          cr_held = (b == rrp_pkg::CH_CR);
        end
      end
      rrp_pkg::MODE_ELEM: begin
        if (b == rrp_pkg::CH_DOLLAR) begin
          num_restart();
          cr_held = 1'b0;
          pmode = rrp_pkg::MODE_LEN;
        end else begin
          array_error();
        end
      end
      rrp_pkg::MODE_LEN: begin
        if (crlf) begin
          cr_held = 1'b0;
          if ((num_neg && num_val != 0) || num_val > len_limit || num_val > LEN_MAX) begin
            array_error();
          end else if (num_val == 0) begin
            close_arg();
          end else begin
            bytes_remaining = num_val;
            pmode = rrp_pkg::MODE_DATA;
          end
        end else begin
          scan_char(b);
          cr_held = (b == rrp_pkg::CH_CR);
        end
      end
      rrp_pkg::MODE_DATA: begin
        add_result(rrp_pkg::KIND_DATA, b);
        bytes_remaining = bytes_remaining - 32'd1;
        if (bytes_remaining == 0) close_arg();
      end
      rrp_pkg::MODE_SKIP: begin
        skips_remaining = skips_remaining - 2'd1;
        if (skips_remaining == 0) begin
          if (args_remaining == 0) begin
            add_result(rrp_pkg::KIND_CMDEND, 8'h00);
            pmode = rrp_pkg::MODE_IDLE;
          end else begin
            pmode = rrp_pkg::MODE_ELEM;
          end
        end
      end
      rrp_pkg::MODE_INLINE: begin
        if (crlf) begin
          cr_held = 1'b0;
          if (!line_tokens) begin
            add_result(rrp_pkg::KIND_ERROR, 8'h00);
          end else begin
            if (token_live) add_result(rrp_pkg::KIND_ARGEND, 8'h00);
            add_result(rrp_pkg::KIND_CMDEND, 8'h00);
          end
          token_live = 1'b0;
          line_tokens = 1'b0;
          pmode = rrp_pkg::MODE_IDLE;
        end else begin
          // a held CR not followed by LF is ordinary data
          if (cr_held) inline_char(rrp_pkg::CH_CR);
          if (b == rrp_pkg::CH_CR) begin
            cr_held = 1'b1;
          end else begin
            cr_held = 1'b0;
            inline_char(b);
          end
        end
      end
      default: pmode = rrp_pkg::MODE_DEAD;
    endcase
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------- request builders

  function automatic void put_byte(input logic [7:0] b);
    cmd_bytes.insert(cmd_bytes.size(), b);
  endfunction

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s.getc(i));
  endfunction

  function automatic void put_line(input string s);
    put_text(s);
    put_byte(rrp_pkg::CH_CR);
    put_byte(rrp_pkg::CH_LF);
  endfunction

  // decimal field with random blanks, sign, leading zeros and trailing junk
  function automatic void put_number(input int unsigned v, input bit minus_zero_ok);
    int unsigned n;
    logic [7:0] c;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    repeat (n) begin
      case ($urandom_range(0, 4))
        0: c = rrp_pkg::CH_SPACE;
        1: c = rrp_pkg::CH_TAB;
        2: c = rrp_pkg::CH_LF;
        3: c = rrp_pkg::CH_VT;
        default: c = rrp_pkg::CH_FF;
      endcase
      put_byte(c);
    end
    case ($urandom_range(0, 7))
      0: put_byte((v == 0 && minus_zero_ok) ? rrp_pkg::CH_MINUS : rrp_pkg::CH_PLUS);
      1: put_byte(rrp_pkg::CH_PLUS);
      default: ;
    endcase
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    repeat (n) put_byte(rrp_pkg::CH_ZERO);
    put_text($sformatf("%0d", v));
    if ($urandom_range(0, 5) == 0) begin
      c = 8'($urandom_range(0, 255));
      if ((c >= rrp_pkg::CH_ZERO && c <= rrp_pkg::CH_NINE) || c == rrp_pkg::CH_CR) c = "z";
      put_byte(c);
      c = 8'($urandom_range(0, 255));
      if (c == rrp_pkg::CH_CR) c = "#";
      put_byte(c);
    end
    put_byte(rrp_pkg::CH_CR);
    put_byte(rrp_pkg::CH_LF);
  endfunction

  function automatic void build_array();
    int unsigned cnt;
    int unsigned len;
    int unsigned cap;
    cap = (arg_limit < 4) ? arg_limit : 4;
    if (arg_limit <= 6 && $urandom_range(0, 3) == 0) cnt = arg_limit;
    else cnt = $urandom_range(1, cap);
    put_byte(rrp_pkg::CH_STAR);
    put_number(cnt, 1'b0);
    repeat (cnt) begin
      if ($urandom_range(0, 19) == 0) len = (len_limit <= 40) ? len_limit : $urandom_range(9, 40);
      else len = $urandom_range(0, (len_limit < 8) ? len_limit : 8);
      put_byte(rrp_pkg::CH_DOLLAR);
      put_number(len, 1'b1);
      repeat (len) put_byte(8'($urandom_range(0, 255)));
      repeat (2) put_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void build_inline();
    int unsigned n;
    logic [7:0] c;
    n = $urandom_range(0, 12);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: c = rrp_pkg::CH_SPACE;
        3: c = 8'($urandom_range(0, 255));
        4: c = rrp_pkg::CH_CR;
        default: c = 8'($urandom_range(8'h61, 8'h7A));
      endcase
      // keep the line inline and in one piece
      if (i == 0 && c == rrp_pkg::CH_STAR) c = rrp_pkg::CH_SPACE;
      if (i > 0 && cmd_bytes[i - 1] == rrp_pkg::CH_CR && c == rrp_pkg::CH_LF)
        c = rrp_pkg::CH_SPACE;
      put_byte(c);
    end
    put_byte(rrp_pkg::CH_CR);
    put_byte(rrp_pkg::CH_LF);
  endfunction

  // one array fault, then bytes that the dead parser must swallow
  function automatic void build_fatal();
    fault_t f;
    f = fault_t'($urandom_range(0, 6));
    put_byte(rrp_pkg::CH_STAR);
    case (f)
      BAD_ZERO_COUNT: put_line("0");
      BAD_NEG_COUNT:  put_line("-3");
      BAD_BIG_COUNT:  put_line($sformatf("%0d", 32'(arg_limit) + 32'd1));
      BAD_NO_DOLLAR: begin
        put_line("1");
        put_text("x");
      end
      BAD_NEG_LEN: begin
        put_line("1");
        put_line("$-2");
      end
      BAD_BIG_LEN: begin
        put_line("1");
        put_line($sformatf("$%0d", 32'(len_limit) + 32'd1));
      end
      default: begin
        put_line("1");
        put_line("$99999999999");
      end
    endcase
    repeat (20) put_byte(8'($urandom_range(0, 255)));
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_byte(input logic [7:0] b, input row_check_t chk,
                           input rrp_pkg::kind_t k, input logic [7:0] d);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    row_chk <= chk;
    row_kind <= k;
    row_data <= d;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // hold input until every expected result is out and the pipe is quiet
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_cmd_bytes();
    foreach (cmd_bytes[i]) send_byte(cmd_bytes[i], CHK_MODEL, rrp_pkg::KIND_DATA, 8'h00);
  endtask

  task automatic set_limits(input logic [rrp_pkg::ARGMAX_W-1:0] argmax,
                            input logic [rrp_pkg::LENMAX_W-1:0] lenmax);
    cfg_wr_en <= 1'b1;
    cfg_index <= rrp_pkg::REG_MAX_ARG_COUNT;
    cfg_data <= rrp_pkg::CFG_DATA_W'(argmax);
    @(posedge clk);
    cfg_index <= rrp_pkg::REG_MAX_BULK_LENGTH;
    cfg_data <= rrp_pkg::CFG_DATA_W'(lenmax);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    arg_limit = argmax;
    len_limit = lenmax;
  endtask

  task automatic send_command();
    cmd_bytes.delete();
    if ($urandom_range(0, 9) < 6) build_array();
    else build_inline();
    send_cmd_bytes();
    if ($urandom_range(0, 39) == 0) drain();
    if ($urandom_range(0, 14) == 0) tx_idle = !tx_idle;
    if ($urandom_range(0, 14) == 0) rx_idle = !rx_idle;
  endtask

  // result side: random stall after each accepted result
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      rx_wait = rx_idle ? $urandom_range(0, 12) : 0;
      if (rx_wait != 0) out_ready <= 1'b0;
    end else if (!out_ready) begin
      if (rx_wait <= 1) out_ready <= 1'b1;
      if (rx_wait != 0) rx_wait--;
    end
  end

  // ---------------------------------------------------------------- checking

  function automatic void note_error(input string msg);
    if (mismatch_count < 10) $display("%0t: %s", $realtime, msg);
    mismatch_count++;
  endfunction

  always @(posedge clk) begin : check_results
    rrp_pkg::result_t want;
    if (rst_n && in_valid && in_ready) begin
      predict_byte(in_byte);
      case (row_chk)
        CHK_MODEL: foreach (step_res[i])
          expected_results.insert(expected_results.size(), step_res[i]);
        CHK_ONE: begin
          want.kind = row_kind;
          want.data = row_data;
          want.last = 1'b1;
          expected_results.insert(expected_results.size(), want);
        end
        default: ;
      endcase
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        note_error($sformatf("unexpected result: kind %0d data %02h last %0b",
                             out_kind, out_data_byte, out_last));
      end else begin
        want = expected_results.pop_front();
        if (out_kind !== want.kind || out_data_byte !== want.data || out_last !== want.last)
          note_error($sformatf({"result mismatch: expected kind %0d data %02h last %0b, ",
                                "got kind %0d data %02h last %0b"},
                               want.kind, want.data, want.last,
                               out_kind, out_data_byte, out_last));
      end
    end
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int unsigned phase_end;
    reset_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_byte(directed_rows[i].b, directed_rows[i].chk, directed_rows[i].k,
                directed_rows[i].d);

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        0: set_limits(16'd1, 30'd0);
        1: set_limits(16'hFFFF, 30'd536870912);
        2: set_limits(16'($urandom_range(1, 6)), 30'($urandom_range(1, 40)));
        3: set_limits(16'($urandom_range(1, 65535)), 30'($urandom_range(0, 536870912)));
        default: set_limits(16'($urandom_range(2, 8)), 30'($urandom_range(8, 64)));
      endcase
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) send_command();
    end

    // an array fault kills the parser until reset, so it comes last
    drain();
    cmd_bytes.delete();
    build_fatal();
    send_cmd_bytes();

    drain();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
